// ===== rtl/field_category_pair_table_macros.svh =====
// assertion macros for the field/category pair table
// expects clk and rst_n to be visible where a macro is used
`ifndef FIELD_CATEGORY_PAIR_TABLE_MACROS_SVH
`define FIELD_CATEGORY_PAIR_TABLE_MACROS_SVH

// same-cycle implication, off during reset
`define FCPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define FCPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fcpt_pkg.sv =====
// shared types, codes and sizes for the field/category pair table
// no dependencies
package fcpt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] field_id;
    logic [30:0] category;
    logic        any_category;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] found_category;
    logic [4:0]  entry_count;
  } out_item_t;

  // one stored pair
  typedef struct packed {
    logic [15:0] field_id;
    logic [30:0] category;
  } entry_t;

  // controls from the sequencer to the whole chain
  typedef struct packed {
    logic                shift;
    logic [CAPACITY-1:0] wr_head;
    logic [CAPACITY-1:0] wr_key;
    entry_t              key;
  } chain_ctl_t;

  // controls seen by one cell
  typedef struct packed {
    logic shift;
    logic wr_head;
    logic wr_key;
  } cell_ctl_t;

endpackage

// ===== rtl/fcpt_cell.sv =====
// one slot of the pair chain: holds a pair, takes its neighbor's or the head's on a shift, or the key
// depends on fcpt_pkg
module fcpt_cell (
  input  logic               clk,
  input  fcpt_pkg::cell_ctl_t ctl,
  input  fcpt_pkg::entry_t   right,
  input  fcpt_pkg::entry_t   head,
  input  fcpt_pkg::entry_t   key,
  output fcpt_pkg::entry_t   data
);
  import fcpt_pkg::*;

  entry_t data_r;

  // append the key, recirculate the head, or take the neighbor
  always_ff @(posedge clk) begin
    if (ctl.wr_key) begin
      data_r <= key;
    end else if (ctl.shift) begin
      data_r <= ctl.wr_head ? head : right;
    end
  end

  assign data = data_r;

endmodule

// ===== rtl/fcpt_ctrl.sv =====
// sequencer: takes requests, walks the chain once per request (not on clear or an empty table), builds results
// depends on fcpt_pkg
module fcpt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fcpt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fcpt_pkg::out_item_t  out_data,
  input  fcpt_pkg::entry_t     head,
  output fcpt_pkg::chain_ctl_t chain_ctl
);
  import fcpt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  entry_t           key_r, key_nxt;
  logic             any_r, any_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic             dup_r, dup_nxt;
  logic             hit_r, hit_nxt;
  logic [30:0]      found_r, found_nxt;
  out_item_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic head_f, head_c, kill;

  // compare the pair at the head against the request key
  assign head_f = (head.field_id == key_r.field_id);
  assign head_c = (head.category == key_r.category);
  assign kill   = (cmd_r == CMD_DELETE) && head_f && (any_r || head_c);

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    any_nxt       = any_r;
    count_nxt     = count_r;
    occ_nxt       = occ_r;
    steps_nxt     = steps_r;
    dup_nxt       = dup_r;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    chain_ctl         = '0;
    chain_ctl.key     = key_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt            = in_data.command;
          key_nxt.field_id   = in_data.field_id;
          key_nxt.category   = in_data.category;
          any_nxt            = in_data.any_category;
          occ_nxt            = count_r;
          steps_nxt          = count_r;
          dup_nxt            = 1'b0;
          hit_nxt            = 1'b0;
          found_nxt          = '0;
          if (in_data.command == CMD_CLEAR) begin
            count_nxt = '0;
            res_nxt   = '{status: ST_DONE, found_category: '0, entry_count: '0};
            state_nxt = S_OUT;
          end else if (count_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      // rotate one pair past the head per cycle, dropping killed pairs
      S_WALK: begin
        chain_ctl.shift = 1'b1;
        for (int i = 0; i < CAPACITY; i++) begin
          chain_ctl.wr_head[i] = !kill && (occ_r == CNT_W'(i + 1));
        end
        if (kill) begin
          occ_nxt = occ_r - 1'b1;
          hit_nxt = 1'b1;
        end
        if (cmd_r == CMD_INSERT && head_f && head_c) begin
          dup_nxt = 1'b1;
        end
        if (cmd_r == CMD_LOOKUP && head_f && !hit_r) begin
          hit_nxt   = 1'b1;
          found_nxt = head.category;
        end
        steps_nxt = steps_r - 1'b1;
        if (steps_r == CNT_W'(1)) begin
          state_nxt = S_FIN;
        end
      end

      // settle status, append on an insert that is new and fits
      S_FIN: begin
        res_nxt.found_category = '0;
        case (cmd_r)
          CMD_INSERT: begin
            if (dup_r) begin
              res_nxt.status = ST_PRESENT;
            end else if (count_r == CNT_W'(CAPACITY)) begin
              res_nxt.status = ST_FULL;
            end else begin
              for (int i = 0; i < CAPACITY; i++) begin
                chain_ctl.wr_key[i] = (count_r == CNT_W'(i));
              end
              count_nxt      = count_r + 1'b1;
              res_nxt.status = ST_DONE;
            end
          end
          CMD_LOOKUP: begin
            res_nxt.status         = hit_r ? ST_DONE : ST_NOT_FOUND;
            res_nxt.found_category = found_r;
          end
          CMD_DELETE: begin
            count_nxt      = occ_r;
            res_nxt.status = hit_r ? ST_DONE : ST_NOT_FOUND;
          end
          default: begin
            res_nxt.status = ST_DONE;
          end
        endcase
        res_nxt.entry_count = 5'(count_nxt);
        state_nxt           = S_OUT;
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers and payload
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    any_r      <= any_nxt;
    occ_r      <= occ_nxt;
    steps_r    <= steps_nxt;
    dup_r      <= dup_nxt;
    hit_r      <= hit_nxt;
    found_r    <= found_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/field_category_pair_table.sv =====
// top level of the field/category pair table: sequencer plus a ring of cells
// depends on fcpt_pkg, fcpt_cell, fcpt_ctrl and the assertion macros
//
// usage
//   in_valid/in_stall/in_data carry one request: command (insert, lookup,
//   delete, clear), field_id, category and any_category. a request is taken
//   when in_valid is high and in_stall is low.
//   out_valid/out_stall/out_data carry one result per request: status,
//   found_category and entry_count, in request order.
//   one request at a time: a request with N pairs held rotates the ring of
//   cells N times past the head cell, then settles in S_FIN and loads the
//   output register in S_OUT; a clear skips the walk and S_FIN. the next
//   request is taken only once the sequencer is back in S_IDLE.
//   a result may wait in the output register under out_stall while the
//   next request is taken and worked on; that request holds in its last
//   stage until the register frees.
//   reset empties the table at once (count to zero, no clearing pass);
//   cell contents are left as they are and never read before written.
`include "field_category_pair_table_macros.svh"

module field_category_pair_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcpt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fcpt_pkg::out_item_t out_data
);
  import fcpt_pkg::*;

  chain_ctl_t chain_ctl;
  entry_t     cell_data [CAPACITY];

  // sequencer
  fcpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head      (cell_data[0]),
    .chain_ctl (chain_ctl)
  );

  // ring of cells, each shifting toward the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t cctl;

    assign cctl.shift   = chain_ctl.shift;
    assign cctl.wr_head = chain_ctl.wr_head[i];
    assign cctl.wr_key  = chain_ctl.wr_key[i];

    fcpt_cell u_cell (
      .clk   (clk),
      .ctl   (cctl),
      .right (cell_data[(i + 1) % CAPACITY]),
      .head  (cell_data[0]),
      .key   (chain_ctl.key),
      .data  (cell_data[i])
    );
  end

  // checks on the sequencer
  `FCPT_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request not held")
  `FCPT_ASSERT_IMPL(a_append_alone, chain_ctl.wr_key != '0, $onehot(chain_ctl.wr_key) && !chain_ctl.shift, "bad append")
  `FCPT_ASSERT_IMPL(a_one_recirc, chain_ctl.shift, $onehot0(chain_ctl.wr_head), "head written twice")
  `FCPT_ASSERT_IMPL(a_result_from_busy, $rose(out_valid), $past(in_stall), "result without request")

endmodule

// ===== sim/field_category_pair_table_tb.sv =====
// self-checking testbench for the field/category pair table
// holds a queue-fed request driver, a result monitor and a predictor of the table
// depends on fcpt_pkg and field_category_pair_table
`timescale 1ns / 100ps

module field_category_pair_table_tb;
  import fcpt_pkg::*;

  localparam int RANDOM_REQUESTS = 900;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = CAPACITY + 20;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // requests waiting to be driven, results waiting to be seen
  in_item_t  pending_requests[$];
  out_item_t pending_results[$];

  // predicted table contents
  logic [15:0] held_fields[CAPACITY];
  logic [30:0] held_cats[CAPACITY];
  int          held_count = 0;

  int fail_count  = 0;
  int cycle_count = 0;

  field_category_pair_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  // random idle length, with occasional stretches of no idling
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // apply one request to the predicted table and return its result
  function automatic out_item_t pair_table_step(input in_item_t rq);
    out_item_t res;
    logic      hit;
    int        wr;
    res = '0;
    hit = 1'b0;
    wr  = 0;
    res.status = ST_DONE;
    case (rq.command)
      CMD_INSERT: begin
        for (int i = 0; i < held_count; i++) begin
          if (held_fields[i] == rq.field_id && held_cats[i] == rq.category) hit = 1'b1;
        end
        // duplicate check comes before the full check
        if (hit) begin
          res.status = ST_PRESENT;
        end else if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          held_fields[held_count] = rq.field_id;
          held_cats[held_count]   = rq.category;
          held_count++;
        end
      end
      CMD_LOOKUP: begin
        res.status = ST_NOT_FOUND;
        // walk backward so the first match in table order wins
        for (int i = held_count - 1; i >= 0; i--) begin
          if (held_fields[i] == rq.field_id) begin
            res.status         = ST_DONE;
            res.found_category = held_cats[i];
          end
        end
      end
      CMD_DELETE: begin
        res.status = ST_NOT_FOUND;
        // remove every match and compact the rest in order
        for (int i = 0; i < held_count; i++) begin
          if (held_fields[i] == rq.field_id &&
              (rq.any_category || held_cats[i] == rq.category)) begin
            res.status = ST_DONE;
          end else begin
            held_fields[wr] = held_fields[i];
            held_cats[wr]   = held_cats[i];
            wr++;
          end
        end
        held_count = wr;
      end
      default: begin
        held_count = 0;
      end
    endcase
    res.entry_count = 5'(held_count);
    return res;
  endfunction

  task automatic push_req(input logic [1:0] cmd, input logic [15:0] fid,
                          input logic [30:0] cat, input logic any);
    in_item_t rq;
    rq.command      = cmd;
    rq.field_id     = fid;
    rq.category     = cat;
    rq.any_category = any;
    pending_requests.push_back(rq);
  endtask

  // request driver
  in_item_t drv_req  = '0;
  logic     drv_live = 1'b0;
  int       drv_gap  = 0;
  int       drv_quiet = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_live = 1'b0;
      drv_gap  = draw_gap(drv_quiet);
    end else begin
      // request taken: predict its result
      if (in_valid && !in_stall) begin
        pending_results.push_back(pair_table_step(in_data));
        drv_live = 1'b0;
      end
      // present the next request once its gap has passed
      if (!drv_live && pending_requests.size() != 0) begin
        if (drv_gap != 0) begin
          drv_gap--;
        end else begin
          drv_req  = pending_requests.pop_front();
          drv_live = 1'b1;
          drv_gap  = draw_gap(drv_quiet);
        end
      end
      in_valid <= drv_live;
      in_data  <= drv_req;
    end
  end

  // result monitor and checker
  out_item_t mon_exp;
  int        mon_hold  = 0;
  int        mon_quiet = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mon_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: %p", out_data));
        end else begin
          mon_exp = pending_results.pop_front();
          if (out_data.status !== mon_exp.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, mon_exp.status));
          if (out_data.found_category !== mon_exp.found_category)
            report_mismatch($sformatf("found_category %0h, expected %0h",
                                      out_data.found_category, mon_exp.found_category));
          if (out_data.entry_count !== mon_exp.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      out_data.entry_count, mon_exp.entry_count));
        end
        mon_hold = draw_gap(mon_quiet);
      end else if (mon_hold != 0) begin
        mon_hold--;
      end
      out_stall <= (mon_hold != 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [15:0] field_pool[6];
    logic [30:0] cat_pool[4];
    logic [1:0]  cmd;
    logic [15:0] fid;
    logic [30:0] cat;
    int          pick;

    // directed: empty table, extremes, duplicates, misses
    push_req(CMD_LOOKUP, 16'h0000, 31'h0, 1'b0);
    push_req(CMD_DELETE, 16'h0000, 31'h0, 1'b1);
    push_req(CMD_INSERT, 16'h0000, 31'h0, 1'b0);
    push_req(CMD_INSERT, 16'hFFFF, 31'h7FFF_FFFF, 1'b1);
    push_req(CMD_INSERT, 16'h0000, 31'h0, 1'b0);
    push_req(CMD_LOOKUP, 16'hFFFF, 31'h7FFF_FFFF, 1'b1);
    push_req(CMD_INSERT, 16'hFFFF, 31'h1, 1'b0);
    push_req(CMD_DELETE, 16'hFFFF, 31'h5, 1'b0);
    push_req(CMD_DELETE, 16'hFFFF, 31'h7FFF_FFFF, 1'b0);
    push_req(CMD_LOOKUP, 16'hFFFF, 31'h0, 1'b0);
    // fill to capacity with two interleaved fields
    for (int k = 0; k < CAPACITY - 2; k++) begin
      push_req(CMD_INSERT, k[0] ? 16'h5A5A : 16'hA5A5, 31'(k + 100), 1'b0);
    end
    push_req(CMD_INSERT, 16'h1234, 31'h3, 1'b0);
    push_req(CMD_INSERT, 16'h0000, 31'h0, 1'b0);
    push_req(CMD_DELETE, 16'hA5A5, 31'h0, 1'b1);
    push_req(CMD_CLEAR, 16'hFFFF, 31'h7FFF_FFFF, 1'b1);

    // random: small pools so pairs collide, fill up and get deleted
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 120 == 0) begin
        foreach (field_pool[i]) field_pool[i] = 16'($urandom);
        foreach (cat_pool[i]) cat_pool[i] = 31'($urandom);
        field_pool[0] = (n % 240 == 0) ? 16'h0000 : 16'hFFFF;
        cat_pool[0]   = (n % 240 == 0) ? 31'h7FFF_FFFF : 31'h0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45)      cmd = CMD_INSERT;
      else if (pick < 72) cmd = CMD_LOOKUP;
      else if (pick < 97) cmd = CMD_DELETE;
      else                cmd = CMD_CLEAR;
      fid = field_pool[$urandom_range(0, 5)];
      cat = cat_pool[$urandom_range(0, 3)];
      // some noise outside the pools
      if ($urandom_range(0, 9) == 0) fid = 16'($urandom);
      if ($urandom_range(0, 9) == 0) cat = 31'($urandom);
      push_req(cmd, fid, cat, 1'($urandom_range(0, 1)));
    end

    // reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every request to be taken and every result to arrive
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
